// ----- rtl/sgfir_pkg.sv -----
// sgfir_pkg: field widths, codes and fixed-point constants of the smoothing fir
// used by smoothing_fir_with_edge_modes; depends on nothing
`default_nettype none

package sgfir_pkg;

   localparam int FUNC_W     = 2;
   localparam int ROW_W      = 5;
   localparam int TAP_W      = 7;
   localparam int POS_W      = 12;
   localparam int OUT_W      = 32;
   localparam int STATUS_W   = 2;
   localparam int HALF_W     = 6;
   localparam int MODE_W     = 2;
   localparam int GAIN_W     = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   localparam int ACC_W   = 48;
   localparam int SUM_W   = ACC_W + 1;
   localparam int MAG_W   = ACC_W - 1;
   localparam int SPLIT_W = 24;
   localparam int MUL_W   = SPLIT_W + GAIN_W;
   localparam int LO_W    = MUL_W + 1;
   localparam int RND_W   = 57;
   localparam int R_W     = 33;
   localparam int WIDE_W  = 64;

   localparam logic signed [ACC_W-1:0]  ACC_MAX  = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [WIDE_W-1:0] WIDE_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic [LO_W-1:0]          RND_HALF = 49'h0_0000_8000_0000;
   localparam logic [R_W-1:0]           R_OVER   = 33'h1_0000_0000;
   localparam logic [R_W-1:0]           R_NEG_MAX = 33'h0_8000_0000;
   localparam logic [R_W-1:0]           R_POS_MAX = 33'h0_7FFF_FFFF;

   localparam logic [HALF_W-1:0] HALF_RESET = 6'd2;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd65536;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD_CENTER = 2'd0,
      FUNC_LOAD_EDGE   = 2'd1,
      FUNC_LOAD_SAMPLE = 2'd2,
      FUNC_QUERY       = 2'd3
   } func_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_POLY     = 2'd0,
      MODE_REFLECT  = 2'd1,
      MODE_PERIODIC = 2'd2,
      MODE_CONSTANT = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK     = 2'd0,
      STATUS_SHORT  = 2'd1,
      STATUS_BEYOND = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HALF_WINDOW   = 2'd0,
      CSR_BOUNDARY_MODE = 2'd1,
      CSR_GAIN          = 2'd2
   } csr_index_type;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_RUN   = 8'b0000_0010,
      S_DRAIN = 8'b0000_0100,
      S_MAG   = 8'b0000_1000,
      S_MULHI = 8'b0001_0000,
      S_MULLO = 8'b0010_0000,
      S_ROUND = 8'b0100_0000,
      S_DONE  = 8'b1000_0000
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/smoothing_fir_with_edge_modes.sv -----
// smoothing_fir_with_edge_modes: windowed weight/sample multiply-accumulate with edge modes
// weights and samples live in two synchronous memories; uses sgfir_pkg
//
//   channel | direction | handshake            | content
//   req     | in        | req_valid/req_stall  | func, edge_row, tap, weight, sample, last, position
//   rsp     | out       | rsp_valid/rsp_stall  | filtered, out_position, status
//   csr     | in        | csr_valid/csr_ready  | register index and write data
//
// loads are written when accepted; a query with status ok walks 2n+1 taps, n = half window,
// on one multiply-accumulate fed from the weight and sample memories, then scales by the gain
// a query with a nonzero status skips the tap walk and gives its result with a zero value
// reset clears control, the registers and the record length; memories hold junk until written
// a result waiting on rsp_stall does not hold off the next transfer; only the next result waits
`default_nettype none

module smoothing_fir_with_edge_modes #(
   parameter int MAX_HALF    = 32,
   parameter int MAX_TAPS    = 65,
   parameter int MAX_RECORD  = 4096,
   parameter int SAMPLE_BITS = 16,
   parameter int WEIGHT_BITS = 24
) (
   input  wire                                   clock,
   input  wire                                   reset,

   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire  [sgfir_pkg::FUNC_W-1:0]          req_func,
   input  wire  [sgfir_pkg::ROW_W-1:0]           req_edge_row,
   input  wire  [sgfir_pkg::TAP_W-1:0]           req_tap,
   input  wire  signed [WEIGHT_BITS-1:0]         req_weight_value,
   input  wire  signed [SAMPLE_BITS-1:0]         req_sample_value,
   input  wire                                   req_sample_last,
   input  wire  [sgfir_pkg::POS_W-1:0]           req_position,

   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic signed [sgfir_pkg::OUT_W-1:0]    rsp_filtered,
   output logic [sgfir_pkg::POS_W-1:0]           rsp_out_position,
   output logic [sgfir_pkg::STATUS_W-1:0]        rsp_status,

   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [sgfir_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [sgfir_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int AW    = $clog2(MAX_RECORD);
   localparam int LW    = $clog2(MAX_RECORD + 1);
   localparam int NW    = $clog2(MAX_HALF + 1);
   localparam int KW    = $clog2(2 * MAX_HALF + 1);
   localparam int RW    = (MAX_HALF > 1) ? $clog2(MAX_HALF) : 1;
   localparam int IW    = ((LW > sgfir_pkg::POS_W) ? LW : sgfir_pkg::POS_W) + 2;
   localparam int WDEPTH = (MAX_HALF + 1) * MAX_TAPS;
   localparam int WAW   = $clog2(WDEPTH);
   localparam int PW    = WEIGHT_BITS + SAMPLE_BITS;
   localparam logic [WAW-1:0] CENTER_BASE = WAW'(MAX_HALF * MAX_TAPS);

   // configuration
   logic [sgfir_pkg::HALF_W-1:0]  half_window_ff;
   sgfir_pkg::mode_type           boundary_mode_ff;
   logic [sgfir_pkg::GAIN_W-1:0]  gain_ff;

   // record
   logic [LW-1:0] wp_ff, wp_in;
   logic [LW-1:0] rec_len_ff, rec_len_in;

   // memories
   logic signed [WEIGHT_BITS-1:0] wmem [WDEPTH];
   logic signed [SAMPLE_BITS-1:0] smem [MAX_RECORD];
   logic signed [WEIGHT_BITS-1:0] w_rd_ff;
   logic signed [SAMPLE_BITS-1:0] s_rd_ff;
   logic [WAW-1:0] w_waddr, w_raddr;
   logic           w_we, s_we;
   logic [AW-1:0]  s_raddr;

   // sequencer
   sgfir_pkg::state_type state_ff, state_in;
   logic [KW-1:0]         k_ff, ws_m1_ff;
   logic signed [IW-1:0]  sidx_ff;
   logic                  down_ff;
   logic [WAW-1:0]        w_base_ff;

   // mac pipeline
   logic                    rd_v_ff, w_ok_ff, prod_v_ff;
   logic signed [PW-1:0]    prod_ff;
   logic signed [WEIGHT_BITS-1:0] w_eff;
   logic signed [sgfir_pkg::ACC_W-1:0]  acc_ff, psat, acc_next;
   logic signed [sgfir_pkg::WIDE_W-1:0] prod_ext;
   logic signed [sgfir_pkg::SUM_W-1:0]  acc_sum;

   // gain scaling
   logic                           neg_ff;
   logic [sgfir_pkg::MAG_W-1:0]    mag_ff;
   logic [sgfir_pkg::SPLIT_W-1:0]  mul_a;
   logic [sgfir_pkg::MUL_W-1:0]    mul_p, hi_ff;
   logic [sgfir_pkg::LO_W-1:0]     lo_ff;
   logic [sgfir_pkg::RND_W-1:0]    rnd_sum;
   logic [sgfir_pkg::R_W-1:0]      r_val;
   logic signed [sgfir_pkg::OUT_W-1:0] scaled;

   // result
   logic signed [sgfir_pkg::OUT_W-1:0] res_filtered_ff;
   logic [sgfir_pkg::POS_W-1:0]        res_pos_ff;
   sgfir_pkg::status_type              res_status_ff;
   logic                               rsp_valid_ff;
   logic signed [sgfir_pkg::OUT_W-1:0] rsp_filtered_ff;
   logic [sgfir_pkg::POS_W-1:0]        rsp_pos_ff;
   sgfir_pkg::status_type              rsp_status_ff;
   logic                               rsp_load;

   // query setup
   logic                  accept, is_query;
   logic [NW-1:0]         n_cur;
   logic signed [IW-1:0]  n_s, ws_s, len_s, pos_s, row_s, sidx_start, smap;
   logic                  short_q, beyond_q, center_q, head_q, poly_q;
   logic [RW-1:0]         row_sel;

   assign req_stall = (state_ff != sgfir_pkg::S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign is_query  = (req_func == sgfir_pkg::FUNC_QUERY);
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_window_ff   <= sgfir_pkg::HALF_RESET;
         boundary_mode_ff <= sgfir_pkg::MODE_POLY;
         gain_ff          <= sgfir_pkg::GAIN_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            sgfir_pkg::CSR_HALF_WINDOW: half_window_ff <= csr_wdata[sgfir_pkg::HALF_W-1:0];
            sgfir_pkg::CSR_BOUNDARY_MODE:
               boundary_mode_ff <= sgfir_pkg::mode_type'(csr_wdata[sgfir_pkg::MODE_W-1:0]);
            sgfir_pkg::CSR_GAIN: gain_ff <= csr_wdata[sgfir_pkg::GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // query decode
   always_comb begin
      n_cur    = (int'(half_window_ff) > MAX_HALF) ? NW'(MAX_HALF) : NW'(half_window_ff);
      n_s      = IW'(n_cur);
      ws_s     = n_s + n_s + IW'(1);
      len_s    = IW'(rec_len_ff);
      pos_s    = IW'(req_position);
      short_q  = len_s < ws_s;
      beyond_q = pos_s >= len_s;
      center_q = (pos_s >= n_s) && (pos_s + n_s < len_s);
      head_q   = pos_s < n_s;
      poly_q   = (boundary_mode_ff == sgfir_pkg::MODE_POLY) && !center_q;
      row_s    = head_q ? pos_s : len_s - IW'(1) - pos_s;
      row_sel  = row_s[RW-1:0];
      if (!poly_q) begin
         sidx_start = pos_s - n_s;
      end else if (head_q) begin
         sidx_start = ws_s - IW'(1);
      end else begin
         sidx_start = len_s - ws_s;
      end
   end

   // load writes
   always_comb begin
      w_we    = 1'b0;
      w_waddr = CENTER_BASE + WAW'(req_tap);
      s_we    = 1'b0;
      wp_in   = wp_ff;
      rec_len_in = rec_len_ff;
      if (accept) begin
         case (req_func)
            sgfir_pkg::FUNC_LOAD_CENTER: begin
               w_we = int'(req_tap) < MAX_TAPS;
            end
            sgfir_pkg::FUNC_LOAD_EDGE: begin
               w_we    = (int'(req_tap) < MAX_TAPS) && (int'(req_edge_row) < MAX_HALF);
               w_waddr = WAW'(req_edge_row) * WAW'(MAX_TAPS) + WAW'(req_tap);
            end
            sgfir_pkg::FUNC_LOAD_SAMPLE: begin
               if (int'(wp_ff) < MAX_RECORD) begin
                  s_we  = 1'b1;
                  wp_in = wp_ff + LW'(1);
               end
               if (req_sample_last) begin
                  rec_len_in = wp_in;
                  wp_in      = '0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         rec_len_ff <= '0;
      end else begin
         wp_ff      <= wp_in;
         rec_len_ff <= rec_len_in;
      end
   end

   // sample index with virtual padding
   always_comb begin
      smap = sidx_ff;
      if (sidx_ff < 0) begin
         case (boundary_mode_ff)
            sgfir_pkg::MODE_REFLECT:  smap = ~sidx_ff;
            sgfir_pkg::MODE_PERIODIC: smap = sidx_ff + len_s;
            sgfir_pkg::MODE_CONSTANT: smap = '0;
            default:                  smap = sidx_ff;
         endcase
      end else if (sidx_ff >= len_s) begin
         case (boundary_mode_ff)
            sgfir_pkg::MODE_REFLECT:  smap = len_s + len_s - IW'(1) - sidx_ff;
            sgfir_pkg::MODE_PERIODIC: smap = sidx_ff - len_s;
            sgfir_pkg::MODE_CONSTANT: smap = len_s - IW'(1);
            default:                  smap = sidx_ff;
         endcase
      end
   end

   assign s_raddr = smap[AW-1:0];
   assign w_raddr = w_base_ff + WAW'(k_ff);

   always_ff @(posedge clock) begin
      if (w_we) begin
         wmem[w_waddr] <= req_weight_value;
      end
      w_rd_ff <= wmem[w_raddr];
   end

   always_ff @(posedge clock) begin
      if (s_we) begin
         smem[wp_ff[AW-1:0]] <= req_sample_value;
      end
      s_rd_ff <= smem[s_raddr];
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      rsp_load = 1'b0;
      case (state_ff)
         sgfir_pkg::S_IDLE: begin
            if (accept && is_query) begin
               state_in = (short_q || beyond_q) ? sgfir_pkg::S_DONE : sgfir_pkg::S_RUN;
            end
         end
         sgfir_pkg::S_RUN: begin
            if (k_ff == ws_m1_ff) begin
               state_in = sgfir_pkg::S_DRAIN;
            end
         end
         sgfir_pkg::S_DRAIN: begin
            if (!rd_v_ff && !prod_v_ff) begin
               state_in = sgfir_pkg::S_MAG;
            end
         end
         sgfir_pkg::S_MAG:   state_in = sgfir_pkg::S_MULHI;
         sgfir_pkg::S_MULHI: state_in = sgfir_pkg::S_MULLO;
         sgfir_pkg::S_MULLO: state_in = sgfir_pkg::S_ROUND;
         sgfir_pkg::S_ROUND: state_in = sgfir_pkg::S_DONE;
         sgfir_pkg::S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = sgfir_pkg::S_IDLE;
            end
         end
         default: state_in = sgfir_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= sgfir_pkg::S_IDLE;
         rd_v_ff   <= 1'b0;
         prod_v_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_v_ff   <= (state_ff == sgfir_pkg::S_RUN);
         prod_v_ff <= rd_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == sgfir_pkg::S_IDLE) begin
         k_ff      <= '0;
         ws_m1_ff  <= KW'({n_cur, 1'b0});
         sidx_ff   <= sidx_start;
         down_ff   <= poly_q && head_q;
         w_base_ff <= poly_q ? WAW'(row_sel) * WAW'(MAX_TAPS) : CENTER_BASE;
         res_pos_ff <= req_position;
         res_status_ff <= short_q ? sgfir_pkg::STATUS_SHORT :
                          beyond_q ? sgfir_pkg::STATUS_BEYOND : sgfir_pkg::STATUS_OK;
         res_filtered_ff <= '0;
      end else if (state_ff == sgfir_pkg::S_RUN) begin
         k_ff    <= k_ff + KW'(1);
         sidx_ff <= down_ff ? sidx_ff - IW'(1) : sidx_ff + IW'(1);
      end else if (state_ff == sgfir_pkg::S_ROUND) begin
         res_filtered_ff <= scaled;
      end
   end

   // multiply-accumulate
   assign w_eff    = w_ok_ff ? w_rd_ff : '0;
   assign prod_ext = sgfir_pkg::WIDE_W'(prod_ff);

   always_comb begin
      if (prod_ext > sgfir_pkg::WIDE_MAX) begin
         psat = sgfir_pkg::ACC_MAX;
      end else if (prod_ext < -sgfir_pkg::WIDE_MAX) begin
         psat = -sgfir_pkg::ACC_MAX;
      end else begin
         psat = prod_ext[sgfir_pkg::ACC_W-1:0];
      end
      acc_sum = sgfir_pkg::SUM_W'(acc_ff) + sgfir_pkg::SUM_W'(psat);
      if (acc_sum > sgfir_pkg::SUM_W'(sgfir_pkg::ACC_MAX)) begin
         acc_next = sgfir_pkg::ACC_MAX;
      end else if (acc_sum < -sgfir_pkg::SUM_W'(sgfir_pkg::ACC_MAX)) begin
         acc_next = -sgfir_pkg::ACC_MAX;
      end else begin
         acc_next = acc_sum[sgfir_pkg::ACC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      w_ok_ff <= int'(k_ff) < MAX_TAPS;
      prod_ff <= w_eff * s_rd_ff;
      if (state_ff == sgfir_pkg::S_IDLE) begin
         acc_ff <= '0;
      end else if (prod_v_ff) begin
         acc_ff <= acc_next;
      end
   end

   // gain: split magnitude times gain, round half away from zero, saturate
   assign mul_a = (state_ff == sgfir_pkg::S_MULHI) ?
                  sgfir_pkg::SPLIT_W'(mag_ff[sgfir_pkg::MAG_W-1:sgfir_pkg::SPLIT_W]) :
                  mag_ff[sgfir_pkg::SPLIT_W-1:0];
   assign mul_p = sgfir_pkg::MUL_W'(mul_a) * sgfir_pkg::MUL_W'(gain_ff);

   always_comb begin
      rnd_sum = sgfir_pkg::RND_W'({hi_ff[39:0], 16'd0})
              + sgfir_pkg::RND_W'(lo_ff[sgfir_pkg::LO_W-1:8]);
      if (hi_ff[sgfir_pkg::MUL_W-1:40] != '0) begin
         r_val = sgfir_pkg::R_OVER;
      end else begin
         r_val = rnd_sum[sgfir_pkg::RND_W-1:24];
      end
      if (neg_ff) begin
         scaled = (r_val > sgfir_pkg::R_NEG_MAX) ? -sgfir_pkg::OUT_W'(sgfir_pkg::R_NEG_MAX)
                                                 : -sgfir_pkg::OUT_W'(r_val);
      end else begin
         scaled = (r_val > sgfir_pkg::R_POS_MAX) ? sgfir_pkg::OUT_W'(sgfir_pkg::R_POS_MAX)
                                                 : sgfir_pkg::OUT_W'(r_val);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == sgfir_pkg::S_MAG) begin
         neg_ff <= acc_ff[sgfir_pkg::ACC_W-1];
         mag_ff <= sgfir_pkg::MAG_W'(acc_ff[sgfir_pkg::ACC_W-1] ? -acc_ff : acc_ff);
      end
      if (state_ff == sgfir_pkg::S_MULHI) begin
         hi_ff <= mul_p;
      end
      if (state_ff == sgfir_pkg::S_MULLO) begin
         lo_ff <= sgfir_pkg::LO_W'(mul_p) + sgfir_pkg::RND_HALF;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_filtered_ff <= res_filtered_ff;
         rsp_pos_ff      <= res_pos_ff;
         rsp_status_ff   <= res_status_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_filtered     = rsp_filtered_ff;
   assign rsp_out_position = rsp_pos_ff;
   assign rsp_status       = rsp_status_ff;

`ifndef SYNTHESIS
   a_sample_in_record: assert property (@(posedge clock) disable iff (reset)
      state_ff == sgfir_pkg::S_RUN |-> (smap >= 0) && (smap < len_s))
      else $error("padded sample index left the record");

   a_pipe_in_walk: assert property (@(posedge clock) disable iff (reset)
      (rd_v_ff || prod_v_ff) |->
         (state_ff == sgfir_pkg::S_RUN || state_ff == sgfir_pkg::S_DRAIN))
      else $error("mac pipeline busy outside the tap walk");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != sgfir_pkg::STATUS_OK |-> rsp_filtered_ff == '0)
      else $error("error status with nonzero value");

   a_wp_bound: assert property (@(posedge clock) disable iff (reset)
      int'(wp_ff) <= MAX_RECORD && int'(rec_len_ff) <= MAX_RECORD)
      else $error("write pointer or record length past the store");

   a_acc_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == sgfir_pkg::S_MAG |->
         (acc_ff <= sgfir_pkg::ACC_MAX) && (acc_ff >= -sgfir_pkg::ACC_MAX))
      else $error("accumulator outside its saturation range");
`endif

endmodule

`default_nettype wire

// ----- tb/smoothing_fir_with_edge_modes_tb.sv -----
// smoothing_fir_with_edge_modes_tb: self-checking bench for the smoothing fir, predicting every
// query result from its own copy of weights, samples and registers; uses sgfir_pkg
// random loads, records and queries run through several register settings and idle patterns
`default_nettype none

module smoothing_fir_with_edge_modes_tb;

   localparam int MAX_HALF     = 32;
   localparam int MAX_TAPS     = 65;
   localparam int MAX_RECORD   = 4096;
   localparam int SAMPLE_W     = 16;
   localparam int WEIGHT_W     = 24;
   localparam int RESET_CYCLES = 9;
   localparam int SETTLE       = 100;
   localparam int STALL_LIMIT  = 5000;
   localparam int HOLD_CYCLES  = 300;
   localparam longint ACC_LIM  = 64'sh7FFF_FFFF_FFFF;
   localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = 24'sh7F_FFFF;
   localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN = 24'sh80_0000;

   typedef struct {
      sgfir_pkg::func_type                func;
      logic [sgfir_pkg::ROW_W-1:0]        row;
      logic [sgfir_pkg::TAP_W-1:0]        tap;
      logic signed [WEIGHT_W-1:0]         weight;
      logic signed [SAMPLE_W-1:0]         sample;
      logic                               last;
      logic [sgfir_pkg::POS_W-1:0]        position;
   } fir_req_type;

   typedef struct {
      logic signed [sgfir_pkg::OUT_W-1:0] filtered;
      logic [sgfir_pkg::POS_W-1:0]        position;
      sgfir_pkg::status_type              status;
   } fir_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                               req_valid = 1'b0;
   logic                               req_stall;
   sgfir_pkg::func_type                req_func = sgfir_pkg::FUNC_LOAD_CENTER;
   logic [sgfir_pkg::ROW_W-1:0]        req_edge_row = '0;
   logic [sgfir_pkg::TAP_W-1:0]        req_tap = '0;
   logic signed [WEIGHT_W-1:0]         req_weight_value = '0;
   logic signed [SAMPLE_W-1:0]         req_sample_value = '0;
   logic                               req_sample_last = 1'b0;
   logic [sgfir_pkg::POS_W-1:0]        req_position = '0;

   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic signed [sgfir_pkg::OUT_W-1:0] rsp_filtered;
   logic [sgfir_pkg::POS_W-1:0]        rsp_out_position;
   logic [sgfir_pkg::STATUS_W-1:0]     rsp_status;

   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   sgfir_pkg::csr_index_type           csr_index = sgfir_pkg::CSR_HALF_WINDOW;
   logic [sgfir_pkg::CSR_DATA_W-1:0]   csr_wdata = '0;

   smoothing_fir_with_edge_modes dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_edge_row     (req_edge_row),
      .req_tap          (req_tap),
      .req_weight_value (req_weight_value),
      .req_sample_value (req_sample_value),
      .req_sample_last  (req_sample_last),
      .req_position     (req_position),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_filtered     (rsp_filtered),
      .rsp_out_position (rsp_out_position),
      .rsp_status       (rsp_status),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   // predicted block state
   logic signed [WEIGHT_W-1:0] center_w [MAX_TAPS];
   logic signed [WEIGHT_W-1:0] edge_w [MAX_HALF][MAX_TAPS];
   logic signed [SAMPLE_W-1:0] sample_mem [MAX_RECORD];
   logic [12:0]                wr_ptr = '0;
   logic [12:0]                rec_len = '0;
   logic [sgfir_pkg::HALF_W-1:0] cfg_half = sgfir_pkg::HALF_RESET;
   sgfir_pkg::mode_type          cfg_mode = sgfir_pkg::MODE_POLY;
   logic [sgfir_pkg::GAIN_W-1:0] cfg_gain = sgfir_pkg::GAIN_RESET;

   // stimulus planning view: what will have been written once the backlog is taken
   bit center_set [MAX_TAPS];
   bit edge_set [MAX_HALF][MAX_TAPS];
   int plan_wp = 0;
   int plan_len = 0;

   fir_req_type request_backlog [$];
   fir_rsp_type expected_outputs [$];
   fir_req_type offered;
   int requests_queued = 0;
   int requests_taken = 0;
   int work_items = 0;
   int results_seen = 0;
   int errors = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int idle_cycles = 0;

   function automatic int active_half();
      return (cfg_half > MAX_HALF) ? MAX_HALF : int'(cfg_half);
   endfunction

   function automatic longint clamp48(longint v);
      if (v > ACC_LIM) return ACC_LIM;
      if (v < -ACC_LIM) return -ACC_LIM;
      return v;
   endfunction

   function automatic longint mac(longint acc, longint w, longint s);
      return clamp48(acc + clamp48(w * s));
   endfunction

   function automatic longint stored_sample(longint idx);
      if (idx < 0 || idx >= longint'(rec_len) || idx >= MAX_RECORD) return 0;
      return longint'(sample_mem[idx]);
   endfunction

   function automatic longint padded_sample(longint idx, longint len);
      if (idx >= 0 && idx < len) return stored_sample(idx);
      case (cfg_mode)
         sgfir_pkg::MODE_REFLECT: begin
            if (idx < 0) begin
               idx = -idx - 1;
               if (idx >= len) idx = len - 1;
            end else begin
               idx = 2 * len - idx - 1;
               if (idx < 0) idx = 0;
            end
         end
         sgfir_pkg::MODE_PERIODIC: idx = (idx < 0) ? idx + len : idx - len;
         sgfir_pkg::MODE_CONSTANT: idx = (idx < 0) ? 0 : len - 1;
         default: return 0;
      endcase
      return stored_sample(idx);
   endfunction

   // sum * gain / 2^32, rounded half away from zero, saturated to 32 bits
   function automatic logic signed [sgfir_pkg::OUT_W-1:0] gain_round(longint sum);
      logic neg;
      longint unsigned mag, g, hi, t, r;
      longint v;
      neg = sum < 0;
      mag = neg ? -sum : sum;
      g = cfg_gain;
      hi = (mag >> 24) * g;
      t = (mag & 64'hFF_FFFF) * g + (64'd1 << 31);
      if (hi >= (64'd1 << 40)) r = 64'd1 << 32;
      else r = ((hi << 16) + (t >> 8)) >> 24;
      if (neg) begin
         if (r > 64'h8000_0000) r = 64'h8000_0000;
         v = -longint'(r);
      end else begin
         if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
         v = longint'(r);
      end
      return v[sgfir_pkg::OUT_W-1:0];
   endfunction

   function automatic fir_rsp_type filter_output(logic [sgfir_pkg::POS_W-1:0] pos);
      fir_rsp_type res;
      int n, ws, k;
      longint len, j, acc;
      n = active_half();
      ws = 2 * n + 1;
      len = rec_len;
      j = pos;
      acc = 0;
      res.position = pos;
      res.filtered = '0;
      res.status = sgfir_pkg::STATUS_OK;
      if (len < ws) begin
         res.status = sgfir_pkg::STATUS_SHORT;
      end else if (j >= len) begin
         res.status = sgfir_pkg::STATUS_BEYOND;
      end else begin
         if (j >= n && j < len - n) begin
            for (k = 0; k < ws; k++) acc = mac(acc, center_w[k], stored_sample(j - n + k));
         end else if (cfg_mode == sgfir_pkg::MODE_POLY) begin
            if (j < n) begin
               for (k = 0; k < ws; k++) acc = mac(acc, edge_w[j][k], stored_sample(ws - 1 - k));
            end else begin
               for (k = 0; k < ws; k++)
                  acc = mac(acc, edge_w[len - 1 - j][k], stored_sample(len - ws + k));
            end
         end else begin
            for (k = 0; k < ws; k++) acc = mac(acc, center_w[k], padded_sample(j - n + k, len));
         end
         res.filtered = gain_round(acc);
      end
      return res;
   endfunction

   function automatic void absorb_request(fir_req_type r);
      case (r.func)
         sgfir_pkg::FUNC_LOAD_CENTER: if (r.tap < MAX_TAPS) center_w[r.tap] = r.weight;
         sgfir_pkg::FUNC_LOAD_EDGE:
            if (r.tap < MAX_TAPS && r.row < MAX_HALF) edge_w[r.row][r.tap] = r.weight;
         sgfir_pkg::FUNC_LOAD_SAMPLE: begin
            if (wr_ptr < MAX_RECORD) begin
               sample_mem[wr_ptr[11:0]] = r.sample;
               wr_ptr = wr_ptr + 13'd1;
            end
            if (r.last) begin
               rec_len = wr_ptr;
               wr_ptr = '0;
            end
         end
         default: expected_outputs.push_back(filter_output(r.position));
      endcase
   endfunction

   function automatic fir_req_type random_request();
      fir_req_type r;
      r.func = sgfir_pkg::func_type'($urandom_range(3));
      r.row = sgfir_pkg::ROW_W'($urandom);
      r.tap = sgfir_pkg::TAP_W'($urandom);
      r.weight = WEIGHT_W'($urandom);
      r.sample = SAMPLE_W'($urandom);
      r.last = 1'($urandom);
      r.position = sgfir_pkg::POS_W'($urandom);
      return r;
   endfunction

   function automatic void queue_request(fir_req_type r);
      case (r.func)
         sgfir_pkg::FUNC_LOAD_CENTER: if (r.tap < MAX_TAPS) center_set[r.tap] = 1'b1;
         sgfir_pkg::FUNC_LOAD_EDGE: if (r.tap < MAX_TAPS) edge_set[r.row][r.tap] = 1'b1;
         sgfir_pkg::FUNC_LOAD_SAMPLE: begin
            if (plan_wp < MAX_RECORD) plan_wp++;
            if (r.last) begin
               plan_len = plan_wp;
               plan_wp = 0;
            end
         end
         default: ;
      endcase
      if (!((r.func == sgfir_pkg::FUNC_LOAD_CENTER || r.func == sgfir_pkg::FUNC_LOAD_EDGE) &&
            r.tap >= MAX_TAPS))
         work_items++;
      request_backlog.push_back(r);
      requests_queued++;
   endfunction

   function automatic logic signed [WEIGHT_W-1:0] pick_weight();
      case ($urandom_range(7))
         0: return WEIGHT_MAX;
         1: return WEIGHT_MIN;
         default: return WEIGHT_W'($urandom);
      endcase
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(7))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic void send_center(int tap, logic signed [WEIGHT_W-1:0] w);
      fir_req_type r;
      r = random_request();
      r.func = sgfir_pkg::FUNC_LOAD_CENTER;
      r.tap = sgfir_pkg::TAP_W'(tap);
      r.weight = w;
      queue_request(r);
   endfunction

   function automatic void send_edge(int row, int tap, logic signed [WEIGHT_W-1:0] w);
      fir_req_type r;
      r = random_request();
      r.func = sgfir_pkg::FUNC_LOAD_EDGE;
      r.row = sgfir_pkg::ROW_W'(row);
      r.tap = sgfir_pkg::TAP_W'(tap);
      r.weight = w;
      queue_request(r);
   endfunction

   function automatic void send_ignored_load();
      fir_req_type r;
      r = random_request();
      r.func = ($urandom_range(1) != 0) ? sgfir_pkg::FUNC_LOAD_CENTER : sgfir_pkg::FUNC_LOAD_EDGE;
      r.tap = sgfir_pkg::TAP_W'($urandom_range(MAX_TAPS, (1 << sgfir_pkg::TAP_W) - 1));
      queue_request(r);
   endfunction

   function automatic void send_sample(int v, logic last);
      fir_req_type r;
      r = random_request();
      r.func = sgfir_pkg::FUNC_LOAD_SAMPLE;
      r.sample = SAMPLE_W'(v);
      r.last = last;
      queue_request(r);
   endfunction

   function automatic void send_record(int len);
      for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
   endfunction

   // weights the query will read get written first, never left undefined
   function automatic void send_query(int pos);
      fir_req_type r;
      int n, ws, row;
      n = active_half();
      ws = 2 * n + 1;
      if (plan_len >= ws && pos < plan_len) begin
         if ((pos >= n && pos < plan_len - n) || cfg_mode != sgfir_pkg::MODE_POLY) begin
            for (int k = 0; k < ws; k++) if (!center_set[k]) send_center(k, pick_weight());
         end else begin
            row = (pos < n) ? pos : plan_len - 1 - pos;
            for (int k = 0; k < ws; k++) if (!edge_set[row][k]) send_edge(row, k, pick_weight());
         end
      end
      r = random_request();
      r.func = sgfir_pkg::FUNC_QUERY;
      r.position = sgfir_pkg::POS_W'(pos);
      queue_request(r);
   endfunction

   function automatic int pick_length();
      int ws, sel;
      ws = 2 * active_half() + 1;
      sel = $urandom_range(9);
      if (sel == 0 && ws > 1) return $urandom_range(1, ws - 1);
      if (sel == 1) return $urandom_range(ws, ws + 200);
      return $urandom_range(ws, ws + 24);
   endfunction

   function automatic int pick_position();
      int n, sel, reach;
      n = active_half();
      sel = $urandom_range(9);
      if (plan_len == 0 || sel == 9) return $urandom_range(MAX_RECORD - 1);
      reach = (n < plan_len) ? n : plan_len - 1;
      if (sel < 3) return $urandom_range(reach);
      if (sel < 6) return plan_len - 1 - int'($urandom_range(reach));
      if (sel < 8) return $urandom_range(plan_len - 1);
      return (plan_len < MAX_RECORD) ? plan_len : MAX_RECORD - 1;
   endfunction

   function automatic void random_burst(int target);
      int first, pick;
      first = work_items;
      if (plan_len < 2 * active_half() + 1) send_record(pick_length());
      while (work_items - first < target) begin
         pick = $urandom_range(19);
         if (pick < 8) send_query(pick_position());
         else if (pick < 11) send_record(pick_length());
         else if (pick == 11) repeat ($urandom_range(1, 6)) send_sample(pick_sample(), 1'b0);
         else if (pick < 15) send_center($urandom_range(MAX_TAPS - 1), pick_weight());
         else if (pick < 17)
            send_edge($urandom_range(MAX_HALF - 1), $urandom_range(MAX_TAPS - 1), pick_weight());
         else send_ignored_load();
      end
   endfunction

   task automatic wait_drain();
      while (requests_taken != requests_queued || expected_outputs.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(sgfir_pkg::csr_index_type idx,
                            logic [sgfir_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      case (idx)
         sgfir_pkg::CSR_HALF_WINDOW: cfg_half = data[sgfir_pkg::HALF_W-1:0];
         sgfir_pkg::CSR_BOUNDARY_MODE:
            cfg_mode = sgfir_pkg::mode_type'(data[sgfir_pkg::MODE_W-1:0]);
         default: cfg_gain = data[sgfir_pkg::GAIN_W-1:0];
      endcase
   endtask

   task automatic apply_config(logic [sgfir_pkg::HALF_W-1:0] half, sgfir_pkg::mode_type mode,
                               logic [sgfir_pkg::GAIN_W-1:0] g, int sidle, int ridle);
      wait_drain();
      write_reg(sgfir_pkg::CSR_HALF_WINDOW, sgfir_pkg::CSR_DATA_W'(half));
      write_reg(sgfir_pkg::CSR_BOUNDARY_MODE, sgfir_pkg::CSR_DATA_W'(mode));
      write_reg(sgfir_pkg::CSR_GAIN, g);
      csr_valid <= 1'b0;
      send_idle_pct = sidle;
      recv_idle_pct = ridle;
   endtask

   always @(posedge clock) begin : drive_requests
      fir_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            absorb_request(offered);
            requests_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = request_backlog.pop_front();
               offered <= nxt;
               req_valid <= 1'b1;
               req_func <= nxt.func;
               req_edge_row <= nxt.row;
               req_tap <= nxt.tap;
               req_weight_value <= nxt.weight;
               req_sample_value <= nxt.sample;
               req_sample_last <= nxt.last;
               req_position <= nxt.position;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_results
      fir_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_outputs.size() == 0) begin
               $error("result for position %0d with none expected", rsp_out_position);
               errors++;
            end else begin
               want = expected_outputs.pop_front();
               if (rsp_filtered !== want.filtered) begin
                  $error("filtered: expected %0d, got %0d", want.filtered, rsp_filtered);
                  errors++;
               end
               if (rsp_out_position !== want.position) begin
                  $error("out_position: expected %0d, got %0d", want.position, rsp_out_position);
                  errors++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  errors++;
               end
            end
         end
         // one long hold-off so the block backs up into its input
         if (hold_left != 0) begin
            hold_left--;
         end else if (!hold_done && results_seen >= 40) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         rsp_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("smoothing_fir_with_edge_modes: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int opening [8];
      int spots [8];
      opening = '{32767, -32768, 1, -1, 0, 12345, -20000, 32767};
      spots = '{0, 1, 2, 5, 6, 7, 8, MAX_RECORD - 1};
      send_idle_pct = 24;
      recv_idle_pct = 84;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, empty record, edges, beyond, short record
      send_query(0);
      send_ignored_load();
      send_ignored_load();
      send_center(0, WEIGHT_MAX);
      send_center(1, WEIGHT_MIN);
      send_edge(0, 0, WEIGHT_MAX);
      send_edge(1, 4, WEIGHT_MIN);
      for (int i = 0; i < 8; i++) send_sample(opening[i], i == 7);
      for (int i = 0; i < 8; i++) send_query(spots[i]);
      send_record(3);
      send_query(1);

      apply_config(6'd1, sgfir_pkg::MODE_REFLECT, 24'd65536, 24, 84);
      random_burst(80);
      apply_config(6'd32, sgfir_pkg::MODE_POLY, 24'hFF_FFFF, 24, 84);
      random_burst(150);
      apply_config(6'd0, sgfir_pkg::MODE_PERIODIC, 24'd1, 84, 24);
      random_burst(80);
      apply_config(6'd63, sgfir_pkg::MODE_CONSTANT, 24'd0, 84, 24);
      random_burst(60);

      apply_config(6'd3, sgfir_pkg::MODE_CONSTANT, sgfir_pkg::GAIN_W'($urandom), 84, 24);
      random_burst(40);

      repeat (4) begin
         apply_config(sgfir_pkg::HALF_W'($urandom_range(1, 10)),
                      sgfir_pkg::mode_type'($urandom_range(3)),
                      sgfir_pkg::GAIN_W'($urandom_range(16384, 262144)), 0, 0);
         random_burst(90);
      end

      wait_drain();
      if (errors == 0 && expected_outputs.size() == 0) begin
         $display("smoothing_fir_with_edge_modes: match");
      end else begin
         $display("smoothing_fir_with_edge_modes: mismatch");
      end
      $finish;
   end

endmodule

`default_nettype wire
